[rtl/gbw_pkg.sv]
// Package for the graph walker: item types, op and status codes.
// Used by the walker top level; depends on nothing.
`default_nettype none
package gbw_pkg;

    localparam int VW        = 5;
    localparam int VSLOTS    = 32;
    localparam int CW        = 6;
    localparam logic [CW-1:0] VCOUNT_RESET = 6'd32;

    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_BFS      = 2'd1;
    localparam logic [1:0] OP_DFS      = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]    op;
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
    } t_in_item;

    typedef struct packed {
        logic [VW-1:0] visited_vertex;
        logic          last;
        logic [1:0]    status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EDGE1,
        S_EDGE2,
        S_REPLY,
        S_B_POP,
        S_B_CUR,
        S_B_EDGE,
        S_B_NBR,
        S_D_TOP,
        S_D_NBR,
        S_D_POPW,
        S_FLUSH
    } t_state;

endpackage
`default_nettype wire

[rtl/gbw_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Uses no package; instanced by the walker top level.
`default_nettype none
module gbw_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

[rtl/graph_bfs_dfs_walker_unit.sv]
// Edge item: decode, one edge-pool write per direction, then the reply. Walks visit
// vertices breadth-first or depth-first, following each neighbor-list entry through a
// registered edge-pool read; one item at a time, input stalled until the last
// result is loaded out.
// Reset (synchronous, active low) empties all neighbor lists via per-vertex valid
// bits and sets vertex_count to 32; pool and work RAM need no clearing pass.
// Top level: graph walker; uses gbw_pkg and gbw_ram.
`default_nettype none
module graph_bfs_dfs_walker_unit #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gbw_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gbw_pkg::t_out_item      o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [gbw_pkg::CW-1:0] i_cfg_data
);
    localparam int VW   = gbw_pkg::VW;
    localparam int POOL = 2 * MAX_EDGES;
    localparam int PW   = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int LW   = $clog2(POOL + 1);          // link: 0 = null, else index+1
    localparam int AW   = $clog2(MAX_VERTICES);      // work RAM address
    localparam int SPW  = $clog2(MAX_VERTICES + 1);  // queue pointers, stack depth
    localparam int EW   = VW + LW;                   // {vertex, link}

    gbw_pkg::t_state r_state, n_state;
    gbw_pkg::t_in_item r_item;
    logic [gbw_pkg::CW-1:0] r_vcount;
    logic [LW-1:0] r_heads [gbw_pkg::VSLOTS];
    logic [gbw_pkg::VSLOTS-1:0] r_head_vld;
    logic [LW-1:0] r_used, n_used;
    logic [gbw_pkg::VSLOTS-1:0] r_vis, n_vis;
    logic [SPW-1:0] r_qh, n_qh, r_qt, n_qt, r_sp, n_sp;
    logic [VW-1:0] r_top_v, n_top_v;
    logic [LW-1:0] r_top_link, n_top_link, r_link, n_link;
    logic [VW-1:0] r_pend_v, n_pend_v;
    logic r_pend_vld, n_pend_vld;
    logic [1:0] r_status, n_status;
    logic r_ovld, n_ovld;
    gbw_pkg::t_out_item r_oitem, n_oitem;

    // head write port
    logic          head_we;
    logic [VW-1:0] head_wa;
    logic [LW-1:0] head_wd;

    // RAM ports
    logic          pool_we, pool_re, work_we, work_re;
    logic [PW-1:0] pool_wa, pool_ra;
    logic [AW-1:0] work_wa, work_ra;
    logic [EW-1:0] pool_wd, pool_rd, work_wd, work_rd;

    logic [VW-1:0] pool_v, work_v;
    logic [LW-1:0] pool_l, work_l;
    assign pool_v = pool_rd[EW-1:LW];
    assign pool_l = pool_rd[LW-1:0];
    assign work_v = work_rd[EW-1:LW];
    assign work_l = work_rd[LW-1:0];

    function automatic logic [LW-1:0] head_of(input logic [VW-1:0] v,
                                              input logic [gbw_pkg::VSLOTS-1:0] vld,
                                              input logic [LW-1:0] h);
        return vld[v] ? h : '0;
    endfunction

    // limit = min(vertex_count, MAX_VERTICES)
    logic [7:0] lim;
    logic       a_bad, b_bad, pool_full;
    assign lim = ({2'b0, r_vcount} > 8'(MAX_VERTICES)) ? 8'(MAX_VERTICES)
                                                       : {2'b0, r_vcount};
    assign a_bad = {3'b0, r_item.vertex_a} >= lim;
    assign b_bad = {3'b0, r_item.vertex_b} >= lim;
    assign pool_full = ({1'b0, r_used} + (LW+1)'(2)) > (LW+1)'(POOL);

    logic [LW-1:0] head_a, head_b, head_pool_v, head_work_v;
    assign head_a      = head_of(r_item.vertex_a, r_head_vld, r_heads[r_item.vertex_a]);
    assign head_b      = head_of(r_item.vertex_b, r_head_vld, r_heads[r_item.vertex_b]);
    assign head_pool_v = head_of(pool_v, r_head_vld, r_heads[pool_v]);
    assign head_work_v = head_of(work_v, r_head_vld, r_heads[work_v]);

    // The output register takes a new item when empty or being drained.
    logic can_emit, ok_emit;
    assign can_emit = !r_ovld || !i_out_stall;
    assign ok_emit  = !r_pend_vld || can_emit;

    logic [SPW-1:0] sp_m1, sp_m2;
    logic [LW-1:0]  link_m1, top_m1;
    assign sp_m1   = r_sp - SPW'(1);
    assign sp_m2   = r_sp - SPW'(2);
    assign link_m1 = r_link - LW'(1);
    assign top_m1  = r_top_link - LW'(1);

    assign o_in_stall  = (r_state != gbw_pkg::S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_item  = r_oitem;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = gbw_pkg::S_DECODE;
                end
            end
            gbw_pkg::S_DECODE: begin
                priority if (r_item.op == gbw_pkg::OP_ADD_EDGE) begin
                    n_state = (a_bad || b_bad || pool_full) ? gbw_pkg::S_REPLY
                                                            : gbw_pkg::S_EDGE1;
                end else if (r_item.op == gbw_pkg::OP_BFS) begin
                    n_state = a_bad ? gbw_pkg::S_REPLY : gbw_pkg::S_B_POP;
                end else if (r_item.op == gbw_pkg::OP_DFS) begin
                    n_state = a_bad ? gbw_pkg::S_REPLY : gbw_pkg::S_D_TOP;
                end else begin
                    n_state = gbw_pkg::S_IDLE;
                end
            end
            gbw_pkg::S_EDGE1: n_state = gbw_pkg::S_EDGE2;
            gbw_pkg::S_EDGE2: n_state = gbw_pkg::S_REPLY;
            gbw_pkg::S_REPLY, gbw_pkg::S_FLUSH: begin
                if (can_emit) begin
                    n_state = gbw_pkg::S_IDLE;
                end
            end
            gbw_pkg::S_B_POP: begin
                n_state = (r_qh == r_qt) ? gbw_pkg::S_FLUSH : gbw_pkg::S_B_CUR;
            end
            gbw_pkg::S_B_CUR: begin
                if (ok_emit) begin
                    n_state = gbw_pkg::S_B_EDGE;
                end
            end
            gbw_pkg::S_B_EDGE: begin
                n_state = (r_link == '0) ? gbw_pkg::S_B_POP : gbw_pkg::S_B_NBR;
            end
            gbw_pkg::S_B_NBR: n_state = gbw_pkg::S_B_EDGE;
            gbw_pkg::S_D_TOP: begin
                priority if (r_top_link != '0) begin
                    n_state = gbw_pkg::S_D_NBR;
                end else if (r_sp == SPW'(1)) begin
                    n_state = gbw_pkg::S_FLUSH;
                end else begin
                    n_state = gbw_pkg::S_D_POPW;
                end
            end
            gbw_pkg::S_D_NBR: begin
                if (r_vis[pool_v] || ok_emit) begin
                    n_state = gbw_pkg::S_D_TOP;
                end
            end
            gbw_pkg::S_D_POPW: n_state = gbw_pkg::S_D_TOP;
            default: n_state = gbw_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_used     = r_used;
        n_vis      = r_vis;
        n_qh       = r_qh;
        n_qt       = r_qt;
        n_sp       = r_sp;
        n_top_v    = r_top_v;
        n_top_link = r_top_link;
        n_link     = r_link;
        n_pend_v   = r_pend_v;
        n_pend_vld = r_pend_vld;
        n_status   = r_status;
        n_ovld     = r_ovld && i_out_stall;
        n_oitem    = r_oitem;
        head_we = 1'b0;  head_wa = '0;  head_wd = '0;
        pool_we = 1'b0;  pool_wa = '0;  pool_wd = '0;
        pool_re = 1'b0;  pool_ra = '0;
        work_we = 1'b0;  work_wa = '0;  work_wd = '0;
        work_re = 1'b0;  work_ra = '0;
        unique case (r_state)
            gbw_pkg::S_IDLE: ;
            gbw_pkg::S_DECODE: begin
                n_status   = (a_bad || (r_item.op == gbw_pkg::OP_ADD_EDGE && b_bad))
                             ? gbw_pkg::ST_RANGE
                             : (pool_full ? gbw_pkg::ST_FULL : gbw_pkg::ST_OK);
                n_vis      = '0;
                n_vis[r_item.vertex_a] = 1'b1;
                n_pend_vld = 1'b0;
                if (r_item.op == gbw_pkg::OP_BFS) begin
                    // seed the queue with the start vertex
                    work_we = 1'b1;
                    work_wa = '0;
                    work_wd = {r_item.vertex_a, LW'(0)};
                    n_qh    = '0;
                    n_qt    = SPW'(1);
                end else if (r_item.op == gbw_pkg::OP_DFS) begin
                    // start vertex is emitted first; top of stack held in registers
                    n_pend_v   = r_item.vertex_a;
                    n_pend_vld = 1'b1;
                    n_top_v    = r_item.vertex_a;
                    n_top_link = head_a;
                    n_sp       = SPW'(1);
                end
            end
            gbw_pkg::S_EDGE1: begin
                pool_we = 1'b1;
                pool_wa = r_used[PW-1:0];
                pool_wd = {r_item.vertex_b, head_a};
                head_we = 1'b1;
                head_wa = r_item.vertex_a;
                head_wd = r_used + LW'(1);
                n_used  = r_used + LW'(1);
            end
            gbw_pkg::S_EDGE2: begin
                pool_we = 1'b1;
                pool_wa = r_used[PW-1:0];
                pool_wd = {r_item.vertex_a, head_b};
                head_we = 1'b1;
                head_wa = r_item.vertex_b;
                head_wd = r_used + LW'(1);
                n_used  = r_used + LW'(1);
            end
            gbw_pkg::S_REPLY: begin
                if (can_emit) begin
                    n_ovld  = 1'b1;
                    n_oitem = '{visited_vertex: '0, last: 1'b1, status: r_status};
                end
            end
            gbw_pkg::S_FLUSH: begin
                if (can_emit) begin
                    n_ovld     = 1'b1;
                    n_oitem    = '{visited_vertex: r_pend_v, last: 1'b1,
                                   status: gbw_pkg::ST_OK};
                    n_pend_vld = 1'b0;
                end
            end
            gbw_pkg::S_B_POP: begin
                if (r_qh != r_qt) begin
                    work_re = 1'b1;
                    work_ra = r_qh[AW-1:0];
                    n_qh    = r_qh + SPW'(1);
                end
            end
            gbw_pkg::S_B_CUR: begin
                if (ok_emit) begin
                    if (r_pend_vld) begin
                        n_ovld  = 1'b1;
                        n_oitem = '{visited_vertex: r_pend_v, last: 1'b0,
                                    status: gbw_pkg::ST_OK};
                    end
                    n_pend_v   = work_v;
                    n_pend_vld = 1'b1;
                    n_link     = head_work_v;
                end
            end
            gbw_pkg::S_B_EDGE: begin
                if (r_link != '0) begin
                    pool_re = 1'b1;
                    pool_ra = link_m1[PW-1:0];
                end
            end
            gbw_pkg::S_B_NBR: begin
                if (!r_vis[pool_v]) begin
                    n_vis[pool_v] = 1'b1;
                    work_we = 1'b1;
                    work_wa = r_qt[AW-1:0];
                    work_wd = {pool_v, LW'(0)};
                    n_qt    = r_qt + SPW'(1);
                end
                n_link = pool_l;
            end
            gbw_pkg::S_D_TOP: begin
                if (r_top_link != '0) begin
                    pool_re = 1'b1;
                    pool_ra = top_m1[PW-1:0];
                end else if (r_sp != SPW'(1)) begin
                    work_re = 1'b1;
                    work_ra = sp_m2[AW-1:0];
                end
            end
            gbw_pkg::S_D_NBR: begin
                if (r_vis[pool_v]) begin
                    n_top_link = pool_l;
                end else if (ok_emit) begin
                    if (r_pend_vld) begin
                        n_ovld  = 1'b1;
                        n_oitem = '{visited_vertex: r_pend_v, last: 1'b0,
                                    status: gbw_pkg::ST_OK};
                    end
                    n_pend_v      = pool_v;
                    n_pend_vld    = 1'b1;
                    n_vis[pool_v] = 1'b1;
                    // push the old top with its advanced link, descend into pool_v
                    work_we    = 1'b1;
                    work_wa    = sp_m1[AW-1:0];
                    work_wd    = {r_top_v, pool_l};
                    n_top_v    = pool_v;
                    n_top_link = head_pool_v;
                    n_sp       = r_sp + SPW'(1);
                end
            end
            gbw_pkg::S_D_POPW: begin
                n_top_v    = work_v;
                n_top_link = work_l;
                n_sp       = sp_m1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gbw_pkg::S_IDLE;
            r_vcount   <= gbw_pkg::VCOUNT_RESET;
            r_head_vld <= '0;
            r_used     <= '0;
            r_vis      <= '0;
            r_qh       <= '0;
            r_qt       <= '0;
            r_sp       <= '0;
            r_pend_vld <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (head_we) begin
                r_head_vld[head_wa] <= 1'b1;
            end
            r_used     <= n_used;
            r_vis      <= n_vis;
            r_qh       <= n_qh;
            r_qt       <= n_qt;
            r_sp       <= n_sp;
            r_pend_vld <= n_pend_vld;
            r_ovld     <= n_ovld;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == gbw_pkg::S_IDLE && i_in_valid) begin
            r_item <= i_in_item;
        end
        if (head_we) begin
            r_heads[head_wa] <= head_wd;
        end
        r_top_v    <= n_top_v;
        r_top_link <= n_top_link;
        r_link     <= n_link;
        r_pend_v   <= n_pend_v;
        r_status   <= n_status;
        r_oitem    <= n_oitem;
    end

    gbw_ram #(.WIDTH(EW), .DEPTH(POOL)) u_pool (
        .i_clk     (i_clk),
        .i_wr_en   (pool_we),
        .i_wr_addr (pool_wa),
        .i_wr_data (pool_wd),
        .i_rd_en   (pool_re),
        .i_rd_addr (pool_ra),
        .o_rd_data (pool_rd)
    );

    // BFS queue or DFS stack, never both in one walk.
    gbw_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_work (
        .i_clk     (i_clk),
        .i_wr_en   (work_we),
        .i_wr_addr (work_wa),
        .i_wr_data (work_wd),
        .i_rd_en   (work_re),
        .i_rd_addr (work_ra),
        .o_rd_data (work_rd)
    );

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_sp} <= (SPW+1)'(MAX_VERTICES)))
        else $error("stack depth beyond vertex count");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbw_pkg::S_B_POP || r_state == gbw_pkg::S_B_CUR) |-> (r_qh <= r_qt))
        else $error("queue head passed tail");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbw_pkg::S_FLUSH && can_emit) |=> (r_ovld && r_oitem.last))
        else $error("walk ended without last item");

    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbw_pkg::S_FLUSH) |-> r_pend_vld)
        else $error("walk ended with nothing visited");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_used} <= (LW+1)'(POOL)))
        else $error("edge pool overrun");
`endif
endmodule
`default_nettype wire
